// File: src/tcq_pkg.sv
// shared types and constants for the two-class queue with starvation guard
package tcq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 16;
	localparam int TAG_W       = 16;
	localparam int THR_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 1'd1;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd3;
	localparam logic [THR_W-1:0] ROW_MAX         = 8'hFF;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_SERVE    = 2'd1,
		OP_PURGE    = 2'd2,
		OP_SET_TIME = 2'd3
	} op_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] patience;
	} entry_t;

	typedef struct packed {
		op_t               operation;
		logic [TAG_W-1:0]  visitor_tag;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] patience;
		logic              is_priority;
		logic [TIME_W-1:0] new_time;
	} in_item_t;

	typedef struct packed {
		logic              served_valid;
		logic [TAG_W-1:0]  served_tag;
		logic [TIME_W-1:0] served_arrival;
		logic [TIME_W-1:0] served_patience;
		logic              served_from_priority;
		logic              add_rejected;
		logic [CNT_W-1:0]  priority_length;
		logic [CNT_W-1:0]  regular_length;
	} out_item_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		logic   purge_start;
		entry_t push_data;
	} fifo_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             busy;
		entry_t           head;
	} fifo_stat_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

// File: src/tcq_if.sv
// request and response channel interfaces
interface tcq_req_if import tcq_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tcq_rsp_if import tcq_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/tcq_cell.sv
// one storage cell of a queue row, loads a new entry or takes its neighbor's
module tcq_cell import tcq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     load_data,
	input  entry_t     next_data,
	output entry_t     data_q
);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

endmodule

// File: src/tcq_fifo.sv
// shifting queue built from a row of cells, head at cell zero
module tcq_fifo import tcq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fifo_cmd_t         cmd,
	input  logic [TIME_W-1:0] cur_time,
	output fifo_stat_t        stat
);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     remain_q;
	entry_t               cell_data [QUEUE_DEPTH];
	cell_ctrl_t           ctrl [QUEUE_DEPTH];
	entry_t               load_data;
	logic                 step;
	logic                 keep;
	logic signed [TIME_W:0] wait_t;

	// purge rotates the head out each step, kept entries go back at the tail
	assign step   = remain_q != '0;
	assign wait_t = $signed({1'b0, cur_time}) - $signed({1'b0, cell_data[0].arrival});
	assign keep   = wait_t <= $signed({1'b0, cell_data[0].patience});
	assign load_data = cmd.push ? cmd.push_data : cell_data[0];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_row
		assign ctrl[i].load  = (cmd.push && count_q == CNT_W'(i))
			|| (step && keep && count_q == CNT_W'(i + 1));
		assign ctrl[i].shift = cmd.pop || step;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			tcq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.load_data (load_data),
				.next_data (cell_data[i]),
				.data_q    (cell_data[i])
			);
		end else begin : g_mid
			tcq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.load_data (load_data),
				.next_data (cell_data[i + 1]),
				.data_q    (cell_data[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			remain_q <= '0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop || (step && !keep)) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.purge_start) begin
				remain_q <= count_q;
			end else if (step) begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	assign stat.count = count_q;
	assign stat.busy  = step;
	assign stat.head  = cell_data[0];

endmodule

// File: src/two_class_queue_starvation_guard.sv
// top level: two queue rows, serve arbiter with starvation guard, purge sequencer
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    operation, visitor_tag, arrival_time, patience,
//                                    is_priority, new_time
//   rsp      out  rsp.valid/ready    served_*, add_rejected, priority_length,
//                                    regular_length
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// add, serve and set time put their result in an output register
// purge walks each queue row through its occupancy once (at most 16 entries):
// each queue row rotates one entry per cycle past the timeout compare
// a new beat is taken once no purge is running and the output register is empty or drains in the same cycle
// arst_n clears occupancy, streak count, threshold (to 3) and current time (to 0)
module two_class_queue_starvation_guard import tcq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	tcq_req_if.sink               req,
	tcq_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_PURGE = 2'b10
	} state_t;

	state_t            state_q;
	logic [THR_W-1:0]  thr_q;
	logic [THR_W-1:0]  row_q;
	logic [TIME_W-1:0] time_q;
	out_item_t         rsp_q;
	logic              rsp_valid_q;

	fifo_cmd_t  prio_cmd;
	fifo_cmd_t  reg_cmd;
	fifo_stat_t prio_stat;
	fifo_stat_t reg_stat;

	logic      out_free;
	logic      accept;
	logic      p_any;
	logic      r_any;
	logic      take_prio;
	logic      take_reg;
	logic      add_ok;
	logic      purge_done;
	out_item_t res;
	entry_t    new_entry;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	assign p_any = prio_stat.count != '0;
	assign r_any = reg_stat.count != '0;

	always_comb begin
		take_prio = 1'b0;
		take_reg  = 1'b0;
		if (row_q < thr_q && p_any) begin
			take_prio = 1'b1;
		end else if (row_q >= thr_q && r_any) begin
			take_reg = 1'b1;
		end else if (!p_any && r_any) begin
			take_reg = 1'b1;
		end else if (p_any && !r_any) begin
			take_prio = 1'b1;
		end
	end

	assign add_ok = req.data.is_priority
		? (prio_stat.count != CNT_W'(QUEUE_DEPTH))
		: (reg_stat.count != CNT_W'(QUEUE_DEPTH));

	assign new_entry = '{
		tag:      req.data.visitor_tag,
		arrival:  req.data.arrival_time,
		patience: req.data.patience
	};

	always_comb begin
		prio_cmd = '0;
		reg_cmd  = '0;
		prio_cmd.push_data = new_entry;
		reg_cmd.push_data  = new_entry;
		if (accept) begin
			case (req.data.operation)
				OP_ADD: begin
					prio_cmd.push = add_ok && req.data.is_priority;
					reg_cmd.push  = add_ok && !req.data.is_priority;
				end
				OP_SERVE: begin
					prio_cmd.pop = take_prio;
					reg_cmd.pop  = take_reg;
				end
				OP_PURGE: begin
					prio_cmd.purge_start = 1'b1;
					reg_cmd.purge_start  = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result of an add, serve or set time operation, lengths as they stand after it
	always_comb begin
		res = '0;
		res.priority_length = prio_stat.count;
		res.regular_length  = reg_stat.count;
		case (req.data.operation)
			OP_ADD: begin
				res.add_rejected = !add_ok;
				if (prio_cmd.push) begin
					res.priority_length = prio_stat.count + 1'b1;
				end
				if (reg_cmd.push) begin
					res.regular_length = reg_stat.count + 1'b1;
				end
			end
			OP_SERVE: begin
				if (take_prio) begin
					res.served_valid         = 1'b1;
					res.served_from_priority = 1'b1;
					res.served_tag           = prio_stat.head.tag;
					res.served_arrival       = prio_stat.head.arrival;
					res.served_patience      = prio_stat.head.patience;
					res.priority_length      = prio_stat.count - 1'b1;
				end else if (take_reg) begin
					res.served_valid    = 1'b1;
					res.served_tag      = reg_stat.head.tag;
					res.served_arrival  = reg_stat.head.arrival;
					res.served_patience = reg_stat.head.patience;
					res.regular_length  = reg_stat.count - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign purge_done = (state_q == S_PURGE) && !prio_stat.busy && !reg_stat.busy;

	tcq_fifo u_prio (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (prio_cmd),
		.cur_time (time_q),
		.stat     (prio_stat)
	);

	tcq_fifo u_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (reg_cmd),
		.cur_time (time_q),
		.stat     (reg_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= THRESHOLD_RESET;
			row_q       <= '0;
			time_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && req.data.operation == OP_PURGE) begin
						state_q <= S_PURGE;
					end
				end
				S_PURGE: begin
					if (purge_done && out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (accept && req.data.operation != OP_PURGE) begin
				rsp_valid_q <= 1'b1;
			end else if (purge_done && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (prio_cmd.pop && row_q != ROW_MAX) begin
				row_q <= row_q + 1'b1;
			end else if (reg_cmd.pop) begin
				row_q <= '0;
			end

			if (accept && req.data.operation == OP_SET_TIME) begin
				time_q <= req.data.new_time;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD:  thr_q  <= cfg_data[THR_W-1:0];
					REG_START_TIME: time_q <= cfg_data[TIME_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.data.operation != OP_PURGE) begin
			rsp_q <= res;
		end else if (purge_done && out_free) begin
			rsp_q                 <= '0;
			rsp_q.priority_length <= prio_stat.count;
			rsp_q.regular_length  <= reg_stat.count;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

// File: src/tcq_checker.sv
// port-level checks for the two-class queue, bound to the top level
module tcq_checker import tcq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input out_item_t rsp_data
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result beat changed while stalled");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.priority_length <= CNT_W'(QUEUE_DEPTH)
			&& rsp_data.regular_length <= CNT_W'(QUEUE_DEPTH))
		else $error("queue length beyond depth");

	a_serve_not_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.served_valid |-> !rsp_data.add_rejected)
		else $error("served and rejected in one beat");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.served_valid |-> rsp_data.served_tag == '0
			&& rsp_data.served_arrival == '0 && rsp_data.served_patience == '0
			&& !rsp_data.served_from_priority)
		else $error("served fields set without a served entry");

	// a served entry leaves room in its queue
	a_served_room: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.served_valid |->
			(rsp_data.served_from_priority
				? rsp_data.priority_length != CNT_W'(QUEUE_DEPTH)
				: rsp_data.regular_length != CNT_W'(QUEUE_DEPTH)))
		else $error("queue full right after a serve");

endmodule

bind two_class_queue_starvation_guard tcq_checker u_tcq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
